/* design/point_to_occupancy_grid_assert.svh */
// ----------------------------------------------------------------------------
// point_to_occupancy_grid_assert
// Assertion macros used by the occupancy grid module.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_OCCUPANCY_GRID_ASSERT_SVH
`define POINT_TO_OCCUPANCY_GRID_ASSERT_SVH

// same-cycle implication, checked out of reset
`define POG_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define POG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pog_pkg.sv */
// ----------------------------------------------------------------------------
// pog_pkg
// Sizes, codes, word types and helpers of the occupancy grid block.
// ----------------------------------------------------------------------------
package pog_pkg;

  // grid geometry
  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLUMNS = 256;
  localparam int WORD_BITS   = 64;
  localparam int ROW_WORDS   = (MAX_COLUMNS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_BITS    = ROW_WORDS * WORD_BITS;
  localparam int ROW_AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW      = $clog2(ROW_BITS);

  // field widths
  localparam int COORD_W     = 32;
  localparam int CELL_SIZE_W = 24;
  localparam int HALF_W      = 8;
  localparam int INDEX_W     = 8;
  localparam int RWORD_W     = 2;
  localparam int ACTION_W    = 2;
  localparam int BITS_OUT_W  = 64;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;

  // active span width: covers the grid limits and twice the largest half count
  localparam int LIMIT_MAX   = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
  localparam int TWICE_HALF  = 2 * ((1 << HALF_W) - 1);
  localparam int SPAN_MAX    = (LIMIT_MAX > TWICE_HALF) ? LIMIT_MAX : TWICE_HALF;
  localparam int SPAN_W      = $clog2(SPAN_MAX + 1);

  // signed quotient plus offset
  localparam int SQ_W        = COORD_W + 2;

  // divider: quotient bits retired per cycle
  localparam int DIV_STEPS   = 2;
  localparam int DIV_CYCLES  = COORD_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_ROWS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_SIZE    = 2'd2;

  // input word
  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [INDEX_W-1:0]        read_row;
    logic [RWORD_W-1:0]        read_word;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [BITS_OUT_W-1:0] cell_bits;
    logic                  point_kept;
    logic [INDEX_W-1:0]    cell_column;
    logic [INDEX_W-1:0]    cell_row;
  } out_word_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // magnitude of a signed coordinate, the most negative value included
  function automatic logic [COORD_W-1:0] coord_mag(input logic [COORD_W-1:0] v);
    return v[COORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  // active span: twice the half count, capped at the grid limit
  function automatic logic [SPAN_W-1:0] active_span(input logic [HALF_W-1:0] half,
                                                    input int limit);
    logic [SPAN_W-1:0] twice;
    twice = SPAN_W'({half, 1'b0});
    return (twice > SPAN_W'(limit)) ? SPAN_W'(limit) : twice;
  endfunction

endpackage

/* design/pog_divider.sv */
// ----------------------------------------------------------------------------
// pog_divider
// Unsigned restoring divider, 32-bit dividend by 24-bit divisor, two
// quotient bits per cycle. Loads on start, pulses done when finished.
// ----------------------------------------------------------------------------
module pog_divider
  import pog_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COORD_W-1:0]     dividend,
  input  logic [CELL_SIZE_W-1:0] divisor,
  output div_status_t            status,
  output logic [COORD_W-1:0]     quotient
);

  logic                   busy_r;
  logic                   done_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [COORD_W-1:0]     acc_r;
  logic [CELL_SIZE_W-1:0] rem_r;
  logic [CELL_SIZE_W-1:0] div_r;

  logic [COORD_W-1:0]     acc_nxt;
  logic [CELL_SIZE_W-1:0] rem_nxt;
  logic [CELL_SIZE_W:0]   trial;
  logic                   last;

  // two compare-subtract steps per cycle
  always_comb begin
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    trial   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial   = {rem_nxt, acc_nxt[COORD_W-1]};
      acc_nxt = {acc_nxt[COORD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt    = CELL_SIZE_W'(trial - {1'b0, div_r});
        acc_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[CELL_SIZE_W-1:0];
      end
    end
  end

  assign last = (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 1'b1;
      busy_r <= !last;
      done_r <= last;
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = acc_r;

endmodule

/* design/point_to_occupancy_grid.sv */
// ----------------------------------------------------------------------------
// point_to_occupancy_grid
// Binary occupancy grid: add a point, read a 64-cell word of a row, or clear
// the grid; one result word per input word. An add that marks a cell divides
// x and y by cell_size in turn on one shared divider that retires two
// quotient bits a cycle, then does a range check and a read-modify-write of
// the grid row. An add whose point falls outside the grid stops after the
// range check, a read does one registered memory read, and a clear, an add
// with cell_size zero or the unused action code 3 go straight to the result.
// The block takes the next input word in the cycle after the result is
// loaded. A result still waiting in the output register holds the block at
// its last step until that word is taken.
// The grid is a row-wide memory with a valid flag per row; a clear drops all
// flags at once, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "point_to_occupancy_grid_assert.svh"

module point_to_occupancy_grid
  import pog_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DIV_X    = 8'b0000_0010,
    S_DIV_Y    = 8'b0000_0100,
    S_CHECK    = 8'b0000_1000,
    S_MEM_RD   = 8'b0001_0000,
    S_MEM_WR   = 8'b0010_0000,
    S_READ_OUT = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  in_word_t                  item_r, item_nxt;
  out_word_t                 res_r, res_nxt;
  out_word_t                 out_data_r, out_data_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SQ_W-1:0]    qx_r, qx_nxt;
  logic signed [SQ_W-1:0]    qy_r, qy_nxt;
  logic [ROW_AW-1:0]         addr_r, addr_nxt;
  logic [COL_AW-1:0]         col_r, col_nxt;
  logic                      rd_ok_r, rd_ok_nxt;
  logic [MAX_ROWS-1:0]       row_valid_r, row_valid_nxt;

  logic [HALF_W-1:0]         half_columns_r;
  logic [HALF_W-1:0]         half_rows_r;
  logic [CELL_SIZE_W-1:0]    cell_size_r;

  logic [ROW_BITS-1:0]       mem [MAX_ROWS];
  logic [ROW_BITS-1:0]       mem_rdata_r;
  logic                      mem_we;
  logic [ROW_BITS-1:0]       mem_wdata;

  logic                      in_accept;
  logic                      div_start;
  logic [COORD_W-1:0]        div_dividend;
  logic [COORD_W-1:0]        div_quotient;
  div_status_t               div_status;
  logic                      q_neg;
  logic [SQ_W-1:0]           q_ext;
  logic signed [SQ_W-1:0]    q_signed;

  logic [SPAN_W-1:0]         col_span;
  logic [SPAN_W-1:0]         row_span;
  logic signed [SQ_W-1:0]    col_span_s;
  logic signed [SQ_W-1:0]    row_span_s;
  logic signed [SQ_W-1:0]    cx;
  logic signed [SQ_W-1:0]    cy;
  logic                      in_grid;
  logic [WORD_BITS-1:0]      word_sel;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared divider: x starts on acceptance, y when x is done
  assign div_start    = (in_accept && (in_data.action == ACT_ADD) && (cell_size_r != '0))
                     || ((state_r == S_DIV_X) && div_status.done);
  assign div_dividend = (state_r == S_IDLE) ? coord_mag(in_data.point_x)
                                            : coord_mag(item_r.point_y);

  pog_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cell_size_r),
    .status   (div_status),
    .quotient (div_quotient)
  );

  // quotient sign follows the coordinate, truncation toward zero
  assign q_neg    = (state_r == S_DIV_X) ? item_r.point_x[COORD_W-1]
                                         : item_r.point_y[COORD_W-1];
  assign q_ext    = SQ_W'(div_quotient);
  assign q_signed = q_neg ? (~q_ext + 1'b1) : q_ext;

  // active grid and cell indexes
  assign col_span   = active_span(half_columns_r, MAX_COLUMNS);
  assign row_span   = active_span(half_rows_r, MAX_ROWS);
  assign col_span_s = SQ_W'(col_span);
  assign row_span_s = SQ_W'(row_span);
  assign cx         = qx_r + SQ_W'(col_span >> 1);
  assign cy         = qy_r + SQ_W'(row_span >> 1);
  assign in_grid    = !cx[SQ_W-1] && (cx < col_span_s) && !cy[SQ_W-1] && (cy < row_span_s);

  // word of the row that was read
  always_comb begin
    word_sel = '0;
    for (int w = 0; w < ROW_WORDS; w++) begin
      if ({30'b0, item_r.read_word} == 32'(w)) begin
        word_sel = mem_rdata_r[w*WORD_BITS +: WORD_BITS];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    addr_nxt      = addr_r;
    col_nxt       = col_r;
    rd_ok_nxt     = rd_ok_r;
    row_valid_nxt = row_valid_r;
    mem_we        = 1'b0;
    mem_wdata     = (row_valid_r[addr_r] ? mem_rdata_r : '0) | (ROW_BITS'(1) << col_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          item_nxt = in_data;
          res_nxt  = '0;
          priority if (in_data.action == ACT_ADD) begin
            state_nxt = (cell_size_r != '0) ? S_DIV_X : S_DONE;
          end else if (in_data.action == ACT_READ) begin
            addr_nxt  = ROW_AW'(in_data.read_row);
            rd_ok_nxt = ({24'b0, in_data.read_row} < 32'(MAX_ROWS))
                     && ({30'b0, in_data.read_word} < 32'(ROW_WORDS));
            state_nxt = S_MEM_RD;
          end else if (in_data.action == ACT_CLEAR) begin
            row_valid_nxt = '0;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV_X: begin
        if (div_status.done) begin
          qx_nxt    = q_signed;
          state_nxt = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_status.done) begin
          qy_nxt    = q_signed;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (in_grid) begin
          res_nxt.point_kept  = 1'b1;
          res_nxt.cell_column = INDEX_W'(cx);
          res_nxt.cell_row    = INDEX_W'(cy);
          addr_nxt            = ROW_AW'(cy);
          col_nxt             = COL_AW'(cx);
          state_nxt           = S_MEM_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MEM_RD: begin
        state_nxt = (item_r.action == ACT_ADD) ? S_MEM_WR : S_READ_OUT;
      end
      S_MEM_WR: begin
        mem_we                = 1'b1;
        row_valid_nxt[addr_r] = 1'b1;
        state_nxt             = S_DONE;
      end
      S_READ_OUT: begin
        if (rd_ok_r && row_valid_r[addr_r]) begin
          res_nxt.cell_bits = BITS_OUT_W'(word_sel);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      row_valid_r <= row_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    addr_r     <= addr_nxt;
    col_r      <= col_nxt;
    rd_ok_r    <= rd_ok_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_columns_r <= HALF_W'(128);
      half_rows_r    <= HALF_W'(128);
      cell_size_r    <= CELL_SIZE_W'(256);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HALF_COLUMNS: half_columns_r <= cfg_data[HALF_W-1:0];
        CFG_HALF_ROWS:    half_rows_r    <= cfg_data[HALF_W-1:0];
        CFG_CELL_SIZE:    cell_size_r    <= cfg_data[CELL_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // grid row memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    if (state_r == S_MEM_RD) begin
      mem_rdata_r <= mem[addr_r];
    end
  end

  // checks
  `POG_ASSERT_IMPLIES(a_idle_div_quiet, in_ready, !div_status.busy,
                      "divider busy while idle")
  `POG_ASSERT_IMPLIES(a_done_in_div, div_status.done,
                      (state_r == S_DIV_X) || (state_r == S_DIV_Y),
                      "divider done outside a divide state")
  `POG_ASSERT_IMPLIES(a_write_kept, mem_we, res_r.point_kept,
                      "grid written for a dropped point")
  `POG_ASSERT_NEXT(a_clear_all, in_accept && (in_data.action == ACT_CLEAR),
                   row_valid_r == '0, "clear left a row valid")

endmodule
